// File: rtl/dtt_pkg.sv
// dtt_pkg: shared types and codes for the deadline timer table.
// Used by dtt_stream_if and deadline_timer_table_top; no dependencies.
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int TIME_W    = 48;
  localparam int ID_W      = 4;
  localparam int FUNC_W    = 3;
  localparam int KIND_W    = 2;
  localparam int ORDER_W   = 32;
  localparam int TIMER_IDS = 1 << ID_W;

  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ARM_ABS   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ARM_DELAY = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PERIODIC  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer_id_res;
    logic [TIME_W-1:0] scheduled_time;
    logic [TIME_W-1:0] fire_time;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [ID_W-1:0]    owner;
    logic [ORDER_W-1:0] order;
  } slot_t;

endpackage

// File: rtl/dtt_stream_if.sv
// dtt_stream_if: valid/ready channel carrying one payload per request.
// Payload type defaults to dtt_pkg::req_t; depends on dtt_pkg.
`timescale 1ns / 1ps
interface dtt_stream_if #(parameter type T = dtt_pkg::req_t);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/deadline_timer_table_top.sv
// deadline_timer_table_top: table of pending timer deadlines with periodic rearm.
// Depends on dtt_pkg and dtt_stream_if. One request at a time, ready only when idle.
// Slots are visited one per cycle: arm searches for the first free slot, clear and
// release pass over every slot, periodic restart does a clear pass then an arm, and tick
// rescans every slot per firing; results leave through a one-deep output register.
// Reset (rst, synchronous) empties the table, order counter and periodic marks.
`timescale 1ns / 1ps
module deadline_timer_table_top #(
  parameter int SLOTS    = 16,
  parameter int MAX_FIRE = 16
) (
  input logic         clk,
  input logic         rst,
  dtt_stream_if.sink   req,
  dtt_stream_if.source rsp
);
  import dtt_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_FIRE + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIRE = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]         state;
  logic [2:0]         ret_state;
  logic [FUNC_W-1:0]  func_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  tv_r;
  logic [TIME_W-1:0]  now_r;

  logic [SLOTS-1:0]   slot_valid;
  logic [CNT_W-1:0]   count;
  logic [ORDER_W-1:0] order_counter;
  logic [TIMER_IDS-1:0] periodic_mark;
  logic [TIME_W-1:0]  period_len [TIMER_IDS];

  slot_t              slot_mem [SLOTS];
  slot_t              rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  slot_t              mem_wdata;

  logic [IDX_W-1:0]   idx;
  logic               issuing;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               scan_done;

  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  logic [TIME_W-1:0]  best_dl;
  logic [ID_W-1:0]    best_owner;
  logic [ORDER_W-1:0] best_order;

  logic               held_valid;
  logic [ID_W-1:0]    held_owner;
  logic [TIME_W-1:0]  held_sched;
  logic [FIRE_W-1:0]  fired;

  logic [TIME_W-1:0]  arm_dl;
  rsp_t               emit_data;
  logic               out_valid;
  rsp_t               out_data;
  logic               out_free;

  logic [TIME_W-1:0]  add_a;
  logic [TIME_W-1:0]  add_b;
  logic [TIME_W:0]    add_sum;
  logic [TIME_W-1:0]  sat_val;
  logic [TIME_W-1:0]  per_val;
  logic [ORDER_W-1:0] ord_diff;
  logic               cand;
  logic               rearm;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;
  assign out_free    = !out_valid || rsp.ready;

  // shared saturating adder
  assign per_val = (tv_r == '0) ? TIME_W'(1) : tv_r;
  always_comb begin
    if (state == S_FIRE) begin
      add_a = best_dl;
      add_b = period_len[best_owner];
    end else begin
      add_a = now_r;
      add_b = (func_r == FUNC_PERIODIC) ? per_val : tv_r;
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign sat_val = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];

  // shared comparator for the tick scan
  assign ord_diff = rd_data.order - best_order;
  assign cand = slot_valid[rd_idx] && (rd_data.deadline <= now_r) &&
                (!best_found || (rd_data.deadline < best_dl) ||
                 ((rd_data.deadline == best_dl) && ord_diff[ORDER_W-1]));
  assign scan_done = rd_vld && (rd_idx == IDX_W'(SLOTS - 1));
  assign rearm = periodic_mark[best_owner];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '{deadline: arm_dl, owner: id_r, order: order_counter};
    if (state == S_FREE && !slot_valid[idx]) begin
      mem_we = 1'b1;
    end else if (state == S_FIRE && rearm) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = '{deadline: sat_val, owner: best_owner, order: order_counter};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret_state     <= S_IDLE;
      slot_valid    <= '0;
      count         <= '0;
      order_counter <= '0;
      periodic_mark <= '0;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      best_found    <= 1'b0;
      held_valid    <= 1'b0;
      fired         <= '0;
      out_valid     <= 1'b0;
      idx           <= '0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // slot pass: address issued one cycle, data checked the next
      if (issuing) begin
        rd_vld <= 1'b1;
        rd_idx <= idx;
        if (idx == IDX_W'(SLOTS - 1)) begin
          issuing <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end else begin
        rd_vld <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_r  <= req.payload.func;
            id_r    <= req.payload.timer_id;
            tv_r    <= req.payload.time_value;
            now_r   <= req.payload.now;
            idx     <= '0;
            rd_vld  <= 1'b0;
            case (req.payload.func)
              FUNC_TICK: begin
                state      <= S_SCAN;
                issuing    <= 1'b1;
                best_found <= 1'b0;
                held_valid <= 1'b0;
                fired      <= '0;
              end
              FUNC_ARM_ABS, FUNC_ARM_DELAY: state <= S_PREP;
              FUNC_CLEAR, FUNC_PERIODIC, FUNC_RELEASE: begin
                state   <= S_CLR;
                issuing <= 1'b1;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_CLR: begin
          if (rd_vld && slot_valid[rd_idx] && rd_data.owner == id_r) begin
            slot_valid[rd_idx] <= 1'b0;
            count              <= count - CNT_W'(1);
          end
          if (scan_done) begin
            emit_data <= '{kind: KIND_ACCEPTED, timer_id_res: id_r,
                           scheduled_time: '0, fire_time: '0, last: 1'b1};
            ret_state <= S_IDLE;
            case (func_r)
              FUNC_PERIODIC: begin
                period_len[id_r]    <= per_val;
                periodic_mark[id_r] <= 1'b1;
                state               <= S_PREP;
              end
              FUNC_RELEASE: begin
                periodic_mark[id_r] <= 1'b0;
                state               <= S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end

        S_PREP: begin
          arm_dl <= (func_r == FUNC_ARM_ABS) ? tv_r : sat_val;
          idx    <= '0;
          if (count == CNT_W'(SLOTS)) begin
            emit_data <= '{kind: KIND_DROPPED, timer_id_res: id_r,
                           scheduled_time: '0, fire_time: '0, last: 1'b1};
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            state <= S_FREE;
          end
        end

        S_FREE: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] <= 1'b1;
            count           <= count + CNT_W'(1);
            order_counter   <= order_counter + ORDER_W'(1);
            emit_data <= '{kind: KIND_ACCEPTED, timer_id_res: id_r,
                           scheduled_time: '0, fire_time: '0, last: 1'b1};
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        S_SCAN: begin
          if (rd_vld && cand) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_dl    <= rd_data.deadline;
            best_owner <= rd_data.owner;
            best_order <= rd_data.order;
          end
          if (scan_done) begin
            emit_data <= '{kind: KIND_FIRED, timer_id_res: held_owner,
                           scheduled_time: held_sched, fire_time: now_r,
                           last: !(best_found || cand)};
            if (best_found || cand) begin
              ret_state <= S_FIRE;
              state     <= held_valid ? S_EMIT : S_FIRE;
            end else begin
              ret_state <= S_IDLE;
              state     <= held_valid ? S_EMIT : S_IDLE;
            end
          end
        end

        S_FIRE: begin
          if (rearm) begin
            order_counter <= order_counter + ORDER_W'(1);
          end else begin
            slot_valid[best_idx] <= 1'b0;
            count                <= count - CNT_W'(1);
          end
          held_valid <= 1'b1;
          held_owner <= best_owner;
          held_sched <= best_dl;
          fired      <= fired + FIRE_W'(1);
          best_found <= 1'b0;
          if (fired == FIRE_W'(MAX_FIRE - 1)) begin
            emit_data <= '{kind: KIND_FIRED, timer_id_res: best_owner,
                           scheduled_time: best_dl, fire_time: now_r, last: 1'b1};
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            idx     <= '0;
            issuing <= 1'b1;
            rd_vld  <= 1'b0;
            state   <= S_SCAN;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= emit_data;
            state     <= ret_state;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
